/* src/clip_stk_pkg.sv */
package clip_stk_pkg;

    localparam int COORD_W = 16;
    localparam int FILL_W  = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_FULL  = 2'd1,
        FAULT_EMPTY = 2'd2
    } t_fault;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  new_left;
        logic signed [COORD_W-1:0]  new_top;
        logic signed [COORD_W-1:0]  new_right;
        logic signed [COORD_W-1:0]  new_bottom;
    } t_in_item;

    typedef struct packed {
        logic                       notify;
        logic                       region_present;
        logic signed [COORD_W-1:0]  cur_left;
        logic signed [COORD_W-1:0]  cur_top;
        logic signed [COORD_W-1:0]  cur_right;
        logic signed [COORD_W-1:0]  cur_bottom;
        logic [1:0]                 fault;
        logic [FILL_W-1:0]          fill_level;
    } t_out_item;

endpackage

/* src/clip_stk_if.sv */
interface clip_stk_in_if
    import clip_stk_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clip_stk_out_if
    import clip_stk_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/clip_stk_ram.sv */
module clip_stk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/clip_stk_isect.sv */
module clip_stk_isect #(
    parameter int CB = 16
) (
    input  logic [4*CB-1:0] i_top,
    input  logic [4*CB-1:0] i_new,
    input  logic            i_on_empty,
    output logic [4*CB-1:0] o_rect
);

    logic signed [CB-1:0] t_l, t_t, t_r, t_b;
    logic signed [CB-1:0] n_l, n_t, n_r, n_b;
    logic signed [CB-1:0] x_l, x_t, x_r, x_b;
    logic                 top_zero;
    logic                 has_area;

    always_comb begin
        {t_b, t_r, t_t, t_l} = i_top;
        {n_b, n_r, n_t, n_l} = i_new;

        x_l = (t_l > n_l) ? t_l : n_l;
        x_t = (t_t > n_t) ? t_t : n_t;
        x_r = (t_r < n_r) ? t_r : n_r;
        x_b = (t_b < n_b) ? t_b : n_b;

        top_zero = (i_top == '0);
        has_area = (x_l < x_r) && (x_t < x_b);

        // first entry goes in as given, even with no area
        if (i_on_empty) begin
            o_rect = i_new;
        end else if (!top_zero && has_area) begin
            o_rect = {x_b, x_r, x_t, x_l};
        end else begin
            o_rect = '0;
        end
    end

endmodule

/* src/clip_stk_top_dummy_placeholder.sv */
module clip_stk_rep #(
    parameter int CB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_update,
    input  logic            i_present,
    input  logic [4*CB-1:0] i_rect,
    output logic            o_differs
);

    logic            r_valid;
    logic            r_present;
    logic [4*CB-1:0] r_rect;

    assign o_differs = !r_valid || (r_present != i_present) ||
                       (i_present && (r_rect != i_rect));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_present <= 1'b0;
        end else if (i_update) begin
            r_valid   <= 1'b1;
            r_present <= i_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect <= '0;
        end else if (i_update) begin
            r_rect <= i_present ? i_rect : '0;
        end
    end

endmodule

/* src/clip_rect_intersection_stack.sv */
// Clip rectangle stack.
// i_cmd carries one item per handshake: a push of a rectangle or a pop of the
// top entry. o_res returns exactly one item for each accepted command: the
// current region after the command, its fill level, a fault code and a notify
// flag that is set when the region differs from the last one reported.
// The rectangles live in a single-port-write, registered-read RAM of
// STACK_DEPTH entries; the edges are held at COORD_BITS and sign-extended on
// the way out.
// Each item passes through ST_IDLE, where it is accepted and the RAM read of the
// entry it needs is issued, and ST_CALC, where it is intersected or selected,
// written back and loaded into the result register. A new item is accepted only
// in ST_IDLE, so not before the previous one has left ST_CALC.
// The output register decouples the sides: a new item is accepted while the
// previous result still waits; if the receiver holds ready low, the block
// waits in ST_CALC until the register frees up.
// Reset empties the stack, clears the report history and drops o_res.valid.
// The RAM needs no clearing: only entries below the fill level are used.
module clip_rect_intersection_stack
    import clip_stk_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    clip_stk_in_if.sink           i_cmd,
    clip_stk_out_if.source        o_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW = 4 * COORD_BITS;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_in_item        r_in;
    t_out_item       r_out, n_out;
    logic            r_out_valid;

    logic            w_accept;
    logic            w_adv;
    logic            w_push;
    logic            w_full;
    logic            w_empty;
    logic            w_re;
    logic            w_we;
    logic [AW-1:0]   w_raddr;
    logic [RW-1:0]   w_rdata;
    logic [RW-1:0]   w_new;
    logic [RW-1:0]   w_isect;
    logic [RW-1:0]   w_cur;
    logic            w_present;
    logic            w_update;
    logic            w_differs;
    t_fault          w_fault;

    function automatic logic [COORD_W-1:0] widen(input logic signed [COORD_BITS-1:0] x);
        return COORD_W'(x);
    endfunction

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_adv    = !r_out_valid || o_res.ready;
    assign w_push   = (r_in.kind == KIND_PUSH);
    assign w_full   = (r_count >= CW'(STACK_DEPTH));
    assign w_empty  = (r_count == '0);

    // push reads the top entry, pop reads the one below it
    assign w_raddr = (i_cmd.data.kind == KIND_PUSH) ? AW'(r_count - CW'(1))
                                                    : AW'(r_count - CW'(2));

    assign w_new = {r_in.new_bottom[COORD_BITS-1:0], r_in.new_right[COORD_BITS-1:0],
                    r_in.new_top[COORD_BITS-1:0], r_in.new_left[COORD_BITS-1:0]};

    clip_stk_ram #(
        .WIDTH (RW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (w_isect),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    clip_stk_isect #(
        .CB (COORD_BITS)
    ) u_isect (
        .i_top      (w_rdata),
        .i_new      (w_new),
        .i_on_empty (w_empty),
        .o_rect     (w_isect)
    );

    clip_stk_rep #(
        .CB (COORD_BITS)
    ) u_rep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (w_update),
        .i_present (w_present),
        .i_rect    (w_cur),
        .o_differs (w_differs)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        w_re        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                w_re        = i_cmd.valid;
            end
            ST_CALC: begin
                i_cmd.ready = 1'b0;
                w_re        = 1'b0;
            end
            default: begin
                i_cmd.ready = 1'b0;
                w_re        = 1'b0;
            end
        endcase
    end

    // result of the held item
    always_comb begin
        n_count   = r_count;
        w_fault   = FAULT_NONE;
        w_cur     = '0;
        w_present = 1'b0;
        if (w_push) begin
            if (w_full) begin
                w_fault   = FAULT_FULL;
                w_cur     = w_rdata;
                w_present = 1'b1;
            end else begin
                n_count   = r_count + CW'(1);
                w_cur     = w_isect;
                w_present = 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_fault = FAULT_EMPTY;
            end else begin
                n_count   = r_count - CW'(1);
                w_present = (r_count != CW'(1));
                w_cur     = w_present ? w_rdata : '0;
            end
        end

        w_update = (r_state == ST_CALC) && w_adv && (w_fault == FAULT_NONE);
        w_we     = (r_state == ST_CALC) && w_adv && w_push && !w_full;

        n_out.notify         = (w_fault == FAULT_NONE) && w_differs;
        n_out.region_present = w_present;
        n_out.cur_left       = widen(w_cur[COORD_BITS-1:0]);
        n_out.cur_top        = widen(w_cur[2*COORD_BITS-1:COORD_BITS]);
        n_out.cur_right      = widen(w_cur[3*COORD_BITS-1:2*COORD_BITS]);
        n_out.cur_bottom     = widen(w_cur[4*COORD_BITS-1:3*COORD_BITS]);
        n_out.fault          = w_fault;
        n_out.fill_level     = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CALC && w_adv) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_cmd.data;
        end
        if (r_state == ST_CALC && w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("fill level beyond stack depth");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CALC))
        else $error("accepted item not processed");

    a_calc_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && w_adv) |=> r_out_valid)
        else $error("result not loaded");

    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault != FAULT_NONE) |-> !r_out.notify)
        else $error("notify raised on a faulted item");

    a_no_region_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.region_present) |->
        (r_out.cur_left == '0 && r_out.cur_top == '0 &&
         r_out.cur_right == '0 && r_out.cur_bottom == '0))
        else $error("edges set with no region");

endmodule
